>>> design/hrgb_pkg.sv
// shared types, constants and helper functions for the hsl to rgb converter
// no dependencies; imported by every module of the block

package hrgb_pkg;

    // hue resolution: one turn is 2**HUE_BITS
    localparam int HUE_BITS = 16;

    // saturation and lightness in units of 1/256, 256 means one
    localparam int SL_W = 9;
    localparam logic [SL_W-1:0] UNIT_SL = SL_W'(256);
    localparam logic [SL_W-1:0] HALF_SL = SL_W'(128);

    // hue scaled by three, one turn is 3 * 2**HUE_BITS
    localparam int TURN_W = HUE_BITS + 2;
    localparam int WIDE_W = TURN_W + 1;
    localparam logic [WIDE_W-1:0] HUE_ONE   = WIDE_W'(64'd1 << HUE_BITS);
    localparam logic [WIDE_W-1:0] HUE_TWO   = WIDE_W'(64'd2 << HUE_BITS);
    localparam logic [WIDE_W-1:0] HUE_THREE = WIDE_W'(64'd3 << HUE_BITS);

    // q, p and q - p in units of 1/65536, at most one
    localparam int Q_W = 17;
    // ramp position 0 .. 2**HUE_BITS
    localparam int SPAN_W = HUE_BITS + 1;
    // level numerator, q * 2**HUE_BITS at most
    localparam int NUM_W = Q_W + HUE_BITS;
    localparam int FRAC_SHIFT = 16 + HUE_BITS;

    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX = '1;

    typedef logic [HUE_BITS-1:0] hue_t;
    typedef logic [SL_W-1:0]     unit_t;
    typedef logic [TURN_W-1:0]   turn_t;
    typedef logic [SPAN_W-1:0]   span_t;
    typedef logic [Q_W-1:0]      level_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [CH_W-1:0]     chan_t;

    typedef struct packed {
        turn_t r;
        turn_t g;
        turn_t b;
    } turn3_t;

    typedef struct packed {
        span_t r;
        span_t g;
        span_t b;
    } span3_t;

    typedef struct packed {
        num_t r;
        num_t g;
        num_t b;
    } num3_t;

    // values above one saturate to one
    function automatic unit_t clamp_unit(input unit_t v);
        return (v > UNIT_SL) ? UNIT_SL : v;
    endfunction

    // position on the piecewise-linear ramp: rise, flat top, fall, flat bottom
    function automatic span_t hue_span(input turn_t t);
        logic [WIDE_W-1:0] t_w;
        logic [WIDE_W-1:0] t2;
        logic [WIDE_W-1:0] back;
        span_t x;
        t_w  = {1'b0, t};
        t2   = {t, 1'b0};
        back = HUE_TWO - t_w;
        priority if (t2 < HUE_ONE)
            x = SPAN_W'(t2);
        else if (t2 < HUE_THREE)
            x = SPAN_W'(HUE_ONE);
        else if (t_w < HUE_TWO)
            x = SPAN_W'({back, 1'b0});
        else
            x = '0;
        return x;
    endfunction

    // floor(num * 255 / 2**FRAC_SHIFT), saturated to a byte
    function automatic chan_t to_byte(input num_t num);
        logic [NUM_W+7:0] scaled;
        logic [NUM_W+7-FRAC_SHIFT:0] top;
        scaled = {num, 8'b0} - {8'b0, num};
        top    = scaled[NUM_W+7:FRAC_SHIFT];
        return (top > {1'b0, CH_MAX}) ? CH_MAX : CH_W'(top);
    endfunction

endpackage

>>> design/hsl_to_rgb_converter.sv
// top level of the hsl to rgb converter: five-stage pipeline ending in an output register
// depends on hrgb_pkg, hrgb_hue_stage, hrgb_level_stage, hrgb_mult_stage, hrgb_sum_stage

// Converts one HSL colour per transfer to 8-bit RGB. Hue is a fraction of a turn
// (hue / 2**16), saturation and lightness are value / 256 with anything at or above
// 256 taken as one. Each channel is floor(255 * component), saturated at 255; zero
// saturation gives grey. The block is a five-stage pipeline with a valid bit per
// stage and takes one transfer every clock cycle while the output side is ready.
// The stage depth is set by the 17 x 17 bit multiplier per channel in the third
// stage. A stage whose successor is empty or moving on keeps accepting, so bubbles
// close up while the output stalls. There is no stored state and no configuration.

module hsl_to_rgb_converter
    import hrgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    // input channel
    input  logic  in_valid,
    output logic  in_ready,
    input  hue_t  hue,
    input  unit_t saturation,
    input  unit_t lightness,
    // output channel
    output logic  out_valid,
    input  logic  out_ready,
    output chan_t red,
    output chan_t green,
    output chan_t blue
);

    // stage 1 -> 2: clamped s and l, scaled hue of each channel
    logic   s1_valid;
    logic   s1_ready;
    unit_t  s1_sat;
    unit_t  s1_light;
    turn3_t s1_turn;

    // stage 2 -> 3: p, q - p and ramp positions
    logic   s2_valid;
    logic   s2_ready;
    level_t s2_p;
    level_t s2_d;
    span3_t s2_span;

    // stage 3 -> 4: products
    logic   s3_valid;
    logic   s3_ready;
    level_t s3_p;
    num3_t  s3_prod;

    // stage 4 -> 5: level numerators
    logic   s4_valid;
    logic   s4_ready;
    num3_t  s4_num;

    // stage 5: output register
    logic   out_valid_reg;
    chan_t  red_reg;
    chan_t  green_reg;
    chan_t  blue_reg;
    chan_t  red_next;
    chan_t  green_next;
    chan_t  blue_next;

    hrgb_hue_stage u_hue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .sat_out    (s1_sat),
        .light_out  (s1_light),
        .turn_out   (s1_turn)
    );

    hrgb_level_stage u_level
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .sat_in    (s1_sat),
        .light_in  (s1_light),
        .turn_in   (s1_turn),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .p_out     (s2_p),
        .d_out     (s2_d),
        .span_out  (s2_span)
    );

    hrgb_mult_stage u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .p_in      (s2_p),
        .d_in      (s2_d),
        .span_in   (s2_span),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .p_out     (s3_p),
        .prod_out  (s3_prod)
    );

    hrgb_sum_stage u_sum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .p_in      (s3_p),
        .prod_in   (s3_prod),
        .out_valid (s4_valid),
        .out_ready (s4_ready),
        .num_out   (s4_num)
    );

    // final scale by 255 and saturation to a byte
    always_comb
    begin
        red_next   = to_byte(s4_num.r);
        green_next = to_byte(s4_num.g);
        blue_next  = to_byte(s4_num.b);
    end

    // output register loads whenever it is empty or its result is being taken
    assign s4_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            out_valid_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid && s4_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

>>> design/hrgb_hue_stage.sv
// first pipeline stage: clamps saturation and lightness, forms the three shifted hues
// depends on hrgb_pkg

module hrgb_hue_stage
    import hrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  hue_t   hue,
    input  unit_t  saturation,
    input  unit_t  lightness,
    output logic   out_valid,
    input  logic   out_ready,
    output unit_t  sat_out,
    output unit_t  light_out,
    output turn3_t turn_out
);

    logic   valid_reg;
    unit_t  sat_reg;
    unit_t  light_reg;
    turn3_t turn_reg;

    logic [WIDE_W-1:0] tg_w;
    logic [WIDE_W-1:0] tr_w;
    logic [WIDE_W-1:0] tb_w;
    turn3_t turn_next;

    always_comb
    begin
        tg_w = {2'b0, hue, 1'b0} + WIDE_W'(hue);
        tr_w = tg_w + HUE_ONE;
        tb_w = tg_w + HUE_TWO;
        if (tr_w >= HUE_THREE)
        begin
            tr_w = tr_w - HUE_THREE;
        end
        if (tb_w >= HUE_THREE)
        begin
            tb_w = tb_w - HUE_THREE;
        end
        turn_next.r = TURN_W'(tr_w);
        turn_next.g = TURN_W'(tg_w);
        turn_next.b = TURN_W'(tb_w);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sat_reg   <= clamp_unit(saturation);
            light_reg <= clamp_unit(lightness);
            turn_reg  <= turn_next;
        end
    end

    assign out_valid = valid_reg;
    assign sat_out   = sat_reg;
    assign light_out = light_reg;
    assign turn_out  = turn_reg;

endmodule

>>> design/hrgb_level_stage.sv
// second pipeline stage: forms p and q - p, and the ramp position of each channel
// depends on hrgb_pkg

module hrgb_level_stage
    import hrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  unit_t  sat_in,
    input  unit_t  light_in,
    input  turn3_t turn_in,
    output logic   out_valid,
    input  logic   out_ready,
    output level_t p_out,
    output level_t d_out,
    output span3_t span_out
);

    localparam int W = 2 * SL_W;

    logic   valid_reg;
    level_t p_reg;
    level_t d_reg;
    span3_t span_reg;

    logic [W-1:0] ls;
    logic [W-1:0] l256;
    logic [W-1:0] s256;
    logic [W-1:0] q_w;
    logic [W-1:0] p_w;
    logic [W-1:0] d_w;
    level_t p_next;
    level_t d_next;
    span3_t span_next;

    always_comb
    begin
        ls   = W'(sat_in) * W'(light_in);
        l256 = W'({light_in, 8'b0});
        s256 = W'({sat_in, 8'b0});
        if (light_in < HALF_SL)
        begin
            q_w = l256 + ls;
        end
        else
        begin
            q_w = l256 + s256 - ls;
        end
        p_w = W'({light_in, 9'b0}) - q_w;
        d_w = q_w - p_w;
        p_next = Q_W'(p_w);
        d_next = Q_W'(d_w);
        span_next.r = hue_span(turn_in.r);
        span_next.g = hue_span(turn_in.g);
        span_next.b = hue_span(turn_in.b);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            p_reg    <= p_next;
            d_reg    <= d_next;
            span_reg <= span_next;
        end
    end

    assign out_valid = valid_reg;
    assign p_out     = p_reg;
    assign d_out     = d_reg;
    assign span_out  = span_reg;

endmodule

>>> design/hrgb_mult_stage.sv
// third pipeline stage: one multiplier per channel, (q - p) times ramp position
// depends on hrgb_pkg

module hrgb_mult_stage
    import hrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  level_t p_in,
    input  level_t d_in,
    input  span3_t span_in,
    output logic   out_valid,
    input  logic   out_ready,
    output level_t p_out,
    output num3_t  prod_out
);

    localparam int PW = Q_W + SPAN_W;

    logic   valid_reg;
    level_t p_reg;
    num3_t  prod_reg;

    logic [PW-1:0] prod_r;
    logic [PW-1:0] prod_g;
    logic [PW-1:0] prod_b;
    num3_t prod_next;

    always_comb
    begin
        prod_r = PW'(d_in) * PW'(span_in.r);
        prod_g = PW'(d_in) * PW'(span_in.g);
        prod_b = PW'(d_in) * PW'(span_in.b);
        prod_next.r = prod_r[NUM_W-1:0];
        prod_next.g = prod_g[NUM_W-1:0];
        prod_next.b = prod_b[NUM_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            p_reg    <= p_in;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign p_out     = p_reg;
    assign prod_out  = prod_reg;

endmodule

>>> design/hrgb_sum_stage.sv
// fourth pipeline stage: adds the p floor to each channel product
// depends on hrgb_pkg

module hrgb_sum_stage
    import hrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  level_t p_in,
    input  num3_t  prod_in,
    output logic   out_valid,
    input  logic   out_ready,
    output num3_t  num_out
);

    logic  valid_reg;
    num3_t num_reg;

    num_t  base;
    num3_t num_next;

    always_comb
    begin
        base = {p_in, {HUE_BITS{1'b0}}};
        num_next.r = base + prod_in.r;
        num_next.g = base + prod_in.g;
        num_next.b = base + prod_in.b;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            num_reg <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign num_out   = num_reg;

endmodule
